>>> rtl/length_prefix_deframer_top_defines.svh
// Assertion macros for the length-prefix deframer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LENGTH_PREFIX_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_TOP_DEFINES_SVH

// Checked only out of reset.
`define LPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lpd_pkg.sv
// Shared types, constants and helpers for the length-prefix deframer.
// No dependencies; used by lpd_core and length_prefix_deframer_top.
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned HDR_W   = 3;

  localparam logic [HDR_W-1:0] HDR_DEFAULT = 3'd2;
  localparam logic [HDR_W-1:0] HDR_MAX     = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_HEADER_BYTES = 1'b0;

  typedef enum logic {
    ST_HEADER  = 1'b0,
    ST_PAYLOAD = 1'b1
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] length;
  } result_t;

  // 0 means the default size, anything above 4 clamps to 4
  function automatic logic [HDR_W-1:0] eff_header(input logic [HDR_W-1:0] hb);
    logic [HDR_W-1:0] r;
    if (hb == '0) r = HDR_DEFAULT;
    else if (hb > HDR_MAX) r = HDR_MAX;
    else r = hb;
    return r;
  endfunction

endpackage

>>> rtl/lpd_core.sv
// Header/payload sequencer of the length-prefix deframer.
// Depends on lpd_pkg; instantiated by length_prefix_deframer_top.
`timescale 1ns / 1ps

module lpd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 in_byte,
  input  logic [lpd_pkg::HDR_W-1:0]  header_bytes,
  output lpd_pkg::result_t           result
);

  lpd_pkg::state_t             state, state_next;
  logic [lpd_pkg::HDR_W-1:0]   header_count, header_count_next;
  logic [lpd_pkg::ACC_W-1:0]   length_acc, length_acc_next;
  logic [lpd_pkg::LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [lpd_pkg::LEN_W-1:0]   current_length, current_length_next;

  logic [lpd_pkg::ACC_W-1:0]   acc_shift;
  logic [lpd_pkg::HDR_W-1:0]   count_inc;
  logic                        hdr_done;
  logic [lpd_pkg::LEN_W-1:0]   rem_dec;

  assign acc_shift = {length_acc[lpd_pkg::ACC_W-9:0], in_byte};
  assign count_inc = header_count + 3'd1;
  assign hdr_done  = (count_inc >= lpd_pkg::eff_header(header_bytes));
  assign rem_dec   = bytes_remaining - 31'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lpd_pkg::ST_HEADER;
      header_count    <= '0;
      length_acc      <= '0;
      bytes_remaining <= '0;
      current_length  <= '0;
    end else begin
      state           <= state_next;
      header_count    <= header_count_next;
      length_acc      <= length_acc_next;
      bytes_remaining <= bytes_remaining_next;
      current_length  <= current_length_next;
    end
  end

  always_comb begin
    state_next           = state;
    header_count_next    = header_count;
    length_acc_next      = length_acc;
    bytes_remaining_next = bytes_remaining;
    current_length_next  = current_length;
    result.valid  = 1'b0;
    result.data   = in_byte;
    result.first  = (bytes_remaining == current_length);
    result.last   = (rem_dec == '0);
    result.length = current_length;

    unique case (state)
      lpd_pkg::ST_HEADER: begin
        if (accept) begin
          if (hdr_done) begin
            header_count_next = '0;
            length_acc_next   = '0;
            // zero or negative lengths are dropped
            if (acc_shift != '0 && !acc_shift[lpd_pkg::ACC_W-1]) begin
              current_length_next  = acc_shift[lpd_pkg::LEN_W-1:0];
              bytes_remaining_next = acc_shift[lpd_pkg::LEN_W-1:0];
              state_next           = lpd_pkg::ST_PAYLOAD;
            end
          end else begin
            header_count_next = count_inc;
            length_acc_next   = acc_shift;
          end
        end
      end
      lpd_pkg::ST_PAYLOAD: begin
        if (accept) begin
          result.valid         = 1'b1;
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) state_next = lpd_pkg::ST_HEADER;
        end
      end
      default: state_next = lpd_pkg::ST_HEADER;
    endcase
  end

endmodule

>>> rtl/length_prefix_deframer_top.sv
// Length-prefix deframer: turns a byte stream into frames of payload bytes.
// Depends on lpd_pkg and lpd_core.
`timescale 1ns / 1ps

// One byte is taken per clock cycle with no bubbles while in_stall is low:
// each accepted byte is parsed in the cycle it arrives and its payload
// transaction, if any, is registered and shown on out_valid the next cycle.
// A single output register separates the two sides, so the input is stalled
// only while that register holds a transaction that the sink is stalling.
// Each frame is a big-endian length header of header_bytes bytes (1 to 4;
// 0 acts as 2, 5 to 7 act as 4) followed by that many payload bytes. Header
// bytes give no output. A length of zero or with bit 31 set is dropped and
// the next byte begins a new header. Each payload byte comes out with
// first_of_frame, last_of_frame and the frame length. header_bytes sits at
// APB byte address 0 and should only be written while the stream is idle;
// a change takes effect at the next header byte.
module length_prefix_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  // payload output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    payload_byte,
  output logic                          first_of_frame,
  output logic                          last_of_frame,
  output logic [lpd_pkg::LEN_W-1:0]     frame_length,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpd_pkg::ADDR_W-1:0]    paddr,
  input  logic [lpd_pkg::DATA_W-1:0]    pwdata,
  output logic [lpd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [lpd_pkg::HDR_W-1:0] header_bytes;
  logic                      accept;
  logic                      load_en;
  logic                      cfg_write;
  lpd_pkg::result_t          result;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= lpd_pkg::HDR_DEFAULT;
    end else if (cfg_write && paddr[2] == lpd_pkg::REG_HEADER_BYTES) begin
      header_bytes <= pwdata[lpd_pkg::HDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lpd_pkg::REG_HEADER_BYTES) begin
      prdata = {{(lpd_pkg::DATA_W-lpd_pkg::HDR_W){1'b0}}, header_bytes};
    end
  end

  // ---------------- handshake ----------------
  // the output register can take a new transaction unless it is full and held
  assign load_en  = !(out_valid && out_stall);
  assign in_stall = !load_en;
  assign accept   = in_valid && load_en;

  lpd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .header_bytes (header_bytes),
    .result       (result)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= result.valid;
    end
  end

  // payload registers hold while stalled; no reset needed
  always_ff @(posedge clk) begin
    if (load_en && result.valid) begin
      payload_byte   <= result.data;
      first_of_frame <= result.first;
      last_of_frame  <= result.last;
      frame_length   <= result.length;
    end
  end

endmodule

>>> rtl/lpd_checker.sv
// Port-level checker for the length-prefix deframer, bound to the top level.
// Depends on lpd_pkg and length_prefix_deframer_top_defines.svh.
`timescale 1ns / 1ps
`include "length_prefix_deframer_top_defines.svh"

module lpd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 payload_byte,
  input logic                       first_of_frame,
  input logic                       last_of_frame,
  input logic [lpd_pkg::LEN_W-1:0]  frame_length,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [lpd_pkg::ADDR_W-1:0] paddr,
  input logic [lpd_pkg::DATA_W-1:0] pwdata,
  input logic [lpd_pkg::DATA_W-1:0] prdata
);

  // a held output transaction keeps its payload
  `LPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(frame_length), "output changed while stalled")

  // nothing comes out of reset
  `LPD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

  // a byte that is both first and last must come from a one-byte frame, and lengths are never zero
  `LPD_ASSERT(a_len_nonzero, out_valid |-> frame_length != '0 && (!(first_of_frame && last_of_frame) || frame_length == 31'd1), "bad frame length on output")

  // a header size write reads back on the next cycle
  `LPD_ASSERT(a_cfg_readback, psel && penable && pwrite && paddr[2] == lpd_pkg::REG_HEADER_BYTES |=> paddr[2] != lpd_pkg::REG_HEADER_BYTES || prdata[2:0] == $past(pwdata[2:0]), "header size readback mismatch")

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .payload_byte   (payload_byte),
  .first_of_frame (first_of_frame),
  .last_of_frame  (last_of_frame),
  .frame_length   (frame_length),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
